### hw/rtl/assert_macros.svh
// assertion macros shared by the checker files of the pedal filter
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RTMPF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rtmpf check failed");

// expression must never be true outside reset
`define RTMPF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("rtmpf forbidden condition seen");

`endif

### hw/rtl/rtmpf_pkg.sv
// shared types and constants of the ratiometric trimmed-mean pedal filter
// no dependencies
`default_nettype none

package rtmpf_pkg;

	localparam int SAMPLE_W = 12;
	localparam int POS_W    = 16;
	localparam int DIVD_W   = 28;
	localparam int DIVS_W   = 12;
	localparam int QUO_W    = 16;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [POS_W-1:0]    pos_t;

	localparam sample_t FULL_SCALE = 12'd4095;
	localparam pos_t    SPAN       = 16'd65534;
	// -32767 in two's complement
	localparam pos_t    POS_MIN    = 16'h8001;
	// start value of the running minimums, above any sample
	localparam logic [SAMPLE_W:0] LO_INIT = 13'h1000;

	typedef enum logic [1:0] {
		REG_ACCEL_LOW  = 2'd0,
		REG_ACCEL_HIGH = 2'd1,
		REG_BRAKE_LOW  = 2'd2,
		REG_BRAKE_HIGH = 2'd3
	} reg_idx_t;

	// control from the merge stage to one lane
	typedef struct packed {
		logic    start;
		logic    ack;
		sample_t supply;
		sample_t pedal;
		sample_t cal_low;
		sample_t cal_high;
	} lane_ctl_t;

	// status from one lane back to the merge stage
	typedef struct packed {
		logic idle;
		logic done;
		pos_t position;
	} lane_st_t;

endpackage

`default_nettype wire

### hw/rtl/rtmpf_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rtmpf_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/rtmpf_div.sv
// serial restoring divider, one quotient bit per cycle, 12 or 16 quotient bits
// depends on rtmpf_pkg
`default_nettype none

module rtmpf_div import rtmpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              wide,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);

	// caller guarantees dividend < divisor << (wide ? 16 : 12)
	logic              busy_q;
	logic              done_q;
	logic              wide_q;
	logic [4:0]        cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [QUO_W-1:0]  dq_q;
	logic [DIVS_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, dq_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			wide_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			dq_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				wide_q <= wide;
				dvs_q  <= divisor;
				if (wide) begin
					cnt_q <= 5'd16;
					rem_q <= dividend[27:16];
					dq_q  <= dividend[15:0];
				end else begin
					cnt_q <= 5'd12;
					rem_q <= dividend[23:12];
					dq_q  <= {dividend[11:0], 4'b0000};
				end
			end else if (busy_q) begin
				rem_q <= fits ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
				dq_q  <= {dq_q[QUO_W-2:0], fits};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = wide_q ? dq_q : {4'b0000, dq_q[11:0]};

endmodule

`default_nettype wire

### hw/rtl/rtmpf_lane.sv
// one pedal channel: ratiometric scaling, rolling window, trimmed mean, mapping
// depends on rtmpf_pkg, rtmpf_ram, rtmpf_div
`default_nettype none

module rtmpf_lane import rtmpf_pkg::*; #(
	parameter int FILTER_DEPTH = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lane_ctl_t                       ctl,
	input  logic [$clog2(FILTER_DEPTH)-1:0] slot,
	input  logic [$clog2(FILTER_DEPTH+1)-1:0] fill,
	output lane_st_t                        st
);

	localparam int SLOT_W = $clog2(FILTER_DEPTH);
	localparam int FILL_W = $clog2(FILTER_DEPTH + 1);
	localparam int TOT_W  = $clog2(FILTER_DEPTH * 4096);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(FILTER_DEPTH - 1);
	// mean = floor(tot * MEAN_REC / 2**MEAN_SH), exact for every TOT_W-bit total
	localparam int MEAN_L  = $clog2(FILTER_DEPTH - 4);
	localparam int MEAN_SH = TOT_W + MEAN_L;
	localparam int REC_W   = TOT_W + 1;
	localparam int PROD_W  = TOT_W + REC_W;
	localparam logic [REC_W-1:0] MEAN_REC =
		REC_W'(((64'd1 << MEAN_SH) + 64'(FILTER_DEPTH - 5)) / 64'(FILTER_DEPTH - 4));

	typedef enum logic [3:0] {
		L_IDLE, L_CSTART, L_CWAIT, L_WRITE, L_SWEEP, L_TRIM,
		L_MEAN, L_MAP, L_XSTART, L_XWAIT, L_DONE
	} lane_state_t;

	lane_state_t         state_q;
	sample_t             supply_q;
	sample_t             pedal_q;
	sample_t             comp_q;
	sample_t             mean_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic                issuing_q;
	logic                take_s1;
	logic                vld_s1;
	logic [TOT_W-1:0]    tot_q;
	sample_t             hi1_q;
	sample_t             hi2_q;
	logic [SAMPLE_W:0]   lo1_q;
	logic [SAMPLE_W:0]   lo2_q;
	logic [DIVD_W-1:0]   num_q;
	sample_t             span_q;
	pos_t                pos_q;

	logic                ram_we;
	logic                ram_re;
	sample_t             ram_rdata;
	sample_t             elem;
	logic [SAMPLE_W:0]   elem_x;
	logic [13:0]         drop_sum;
	logic [23:0]         comp_num;
	logic [PROD_W-1:0]   mean_prod;
	sample_t             level;
	logic                div_start;
	logic                div_wide;
	logic [DIVD_W-1:0]   div_dividend;
	logic [DIVS_W-1:0]   div_divisor;
	logic                div_done;
	logic [QUO_W-1:0]    div_quo;

	// pedal already clamped to the supply, times 4095
	assign comp_num = {pedal_q, 12'b0} - 24'(pedal_q);

	// entries past the fill count are read as zero, whatever the ram holds
	assign elem     = vld_s1 ? ram_rdata : '0;
	assign elem_x   = {1'b0, elem};
	assign drop_sum = 14'(hi1_q) + 14'(hi2_q) + 14'(lo1_q[SAMPLE_W-1:0])
		+ 14'(lo2_q[SAMPLE_W-1:0]);

	// trimmed total over FILTER_DEPTH - 4 by reciprocal multiply
	assign mean_prod = PROD_W'(tot_q) * PROD_W'(MEAN_REC);

	always_comb begin
		if (mean_q < ctl.cal_low) begin
			level = ctl.cal_low;
		end else if (mean_q > ctl.cal_high) begin
			level = ctl.cal_high;
		end else begin
			level = mean_q;
		end
	end

	assign ram_we    = state_q == L_WRITE;
	assign ram_re    = (state_q == L_SWEEP) && issuing_q;
	assign div_start = (state_q == L_CSTART) || (state_q == L_XSTART);

	always_comb begin
		case (state_q)
			L_CSTART: begin
				div_wide     = 1'b0;
				div_dividend = DIVD_W'(comp_num);
				div_divisor  = supply_q;
			end
			default: begin
				div_wide     = 1'b1;
				div_dividend = num_q;
				div_divisor  = span_q;
			end
		endcase
	end

	rtmpf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(FILTER_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (comp_q),
		.re    (ram_re),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	rtmpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.wide     (div_wide),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= L_IDLE;
			supply_q  <= '0;
			pedal_q   <= '0;
			comp_q    <= '0;
			mean_q    <= '0;
			slot_q    <= '0;
			fill_q    <= '0;
			cnt_q     <= '0;
			issuing_q <= 1'b0;
			take_s1   <= 1'b0;
			vld_s1    <= 1'b0;
			tot_q     <= '0;
			hi1_q     <= '0;
			hi2_q     <= '0;
			lo1_q     <= LO_INIT;
			lo2_q     <= LO_INIT;
			num_q     <= '0;
			span_q    <= '0;
			pos_q     <= POS_MIN;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (ctl.start) begin
						supply_q <= ctl.supply;
						pedal_q  <= (ctl.pedal > ctl.supply) ? ctl.supply : ctl.pedal;
						slot_q   <= slot;
						fill_q   <= fill;
						comp_q   <= '0;
						state_q  <= (ctl.supply == '0) ? L_WRITE : L_CSTART;
					end
				end
				L_CSTART: begin
					state_q <= L_CWAIT;
				end
				L_CWAIT: begin
					if (div_done) begin
						comp_q  <= div_quo[SAMPLE_W-1:0];
						state_q <= L_WRITE;
					end
				end
				L_WRITE: begin
					cnt_q     <= '0;
					issuing_q <= 1'b1;
					take_s1   <= 1'b0;
					tot_q     <= '0;
					hi1_q     <= '0;
					hi2_q     <= '0;
					lo1_q     <= LO_INIT;
					lo2_q     <= LO_INIT;
					state_q   <= L_SWEEP;
				end
				L_SWEEP: begin
					// the accumulate step takes each read in the cycle after it is issued
					take_s1 <= issuing_q;
					vld_s1  <= FILL_W'(cnt_q) < fill_q;
					if (issuing_q) begin
						if (cnt_q == LAST_IDX) begin
							issuing_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (take_s1) begin
						tot_q <= tot_q + TOT_W'(elem);
						if (elem > hi1_q) begin
							hi2_q <= hi1_q;
							hi1_q <= elem;
						end else if (elem > hi2_q) begin
							hi2_q <= elem;
						end
						if (elem_x < lo1_q) begin
							lo2_q <= lo1_q;
							lo1_q <= elem_x;
						end else if (elem_x < lo2_q) begin
							lo2_q <= elem_x;
						end
					end
					if (!issuing_q && !take_s1) begin
						state_q <= L_TRIM;
					end
				end
				L_TRIM: begin
					tot_q   <= tot_q - TOT_W'(drop_sum);
					state_q <= L_MEAN;
				end
				L_MEAN: begin
					mean_q  <= mean_prod[MEAN_SH +: SAMPLE_W];
					state_q <= L_MAP;
				end
				L_MAP: begin
					if (ctl.cal_high <= ctl.cal_low) begin
						pos_q   <= POS_MIN;
						state_q <= L_DONE;
					end else begin
						num_q   <= DIVD_W'(level - ctl.cal_low) * DIVD_W'(SPAN);
						span_q  <= ctl.cal_high - ctl.cal_low;
						state_q <= L_XSTART;
					end
				end
				L_XSTART: begin
					state_q <= L_XWAIT;
				end
				L_XWAIT: begin
					if (div_done) begin
						pos_q   <= div_quo + POS_MIN;
						state_q <= L_DONE;
					end
				end
				L_DONE: begin
					if (ctl.ack) begin
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign st.idle     = state_q == L_IDLE;
	assign st.done     = state_q == L_DONE;
	assign st.position = pos_q;

endmodule

`default_nettype wire

### hw/rtl/ratiometric_trimmed_mean_pedal_filter_unit.sv
// top level of the ratiometric trimmed-mean pedal filter
// depends on rtmpf_pkg, rtmpf_lane (which uses rtmpf_ram and rtmpf_div)
//
// s_axis carries one sample set per item: supply, accelerator and brake readings;
// m_axis returns one item per input item with the filtered, calibrated accelerator
// and brake positions as signed 16-bit values. the apb port holds four 12-bit
// calibration registers at byte addresses 0, 4, 8 and 12 (accel low, accel high,
// brake low, brake high); write them only while the block is idle.
// two lanes, one per pedal, start together; the merge stage waits for both and
// loads the output register. between accept and m_axis_tvalid an item goes through
// a 12-step serial divide for the supply ratio, a pass of FILTER_DEPTH reads over
// the window ram, a reciprocal multiply for the mean and a 16-step divide for the
// calibration map. zero supply skips the first divide; a lane with an empty or
// inverted range skips the last and waits for the other. one item is in the lanes
// at a time, so the next item is accepted only after both lanes hand theirs over.
// reset empties both windows (every entry reads as zero until written), sets the
// write slot to zero and the calibration to 0..4095. while the receiver stalls the
// finished item waits in the output register and the next item is still taken and
// worked on; the lanes then hold their result until the output register frees up.
`default_nettype none

module ratiometric_trimmed_mean_pedal_filter_unit import rtmpf_pkg::*; #(
	parameter int FILTER_DEPTH = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample set in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // supply_sample[11:0], accel_sample[23:12],
	                                   // brake_sample[35:24], zero [39:36]
	// positions out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // accel_position[15:0], brake_position[31:16]
	// calibration registers
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOT_W = $clog2(FILTER_DEPTH);
	localparam int FILL_W = $clog2(FILTER_DEPTH + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FILTER_DEPTH - 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(FILTER_DEPTH);

	// calibration registers
	sample_t accel_low_q;
	sample_t accel_high_q;
	sample_t brake_low_q;
	sample_t brake_high_q;

	// window bookkeeping shared by both lanes
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;

	// output register
	logic        m_valid_q;
	logic [31:0] m_data_q;

	logic      in_accept;
	logic      cfg_write;
	reg_idx_t  cfg_idx;
	logic      merge;
	lane_ctl_t ctl_accel;
	lane_ctl_t ctl_brake;
	lane_st_t  st_accel;
	lane_st_t  st_brake;

	// ---------------- configuration port ----------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	// byte offset within a word is ignored
	assign cfg_idx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_low_q  <= '0;
			accel_high_q <= FULL_SCALE;
			brake_low_q  <= '0;
			brake_high_q <= FULL_SCALE;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_ACCEL_LOW:  accel_low_q  <= pwdata[SAMPLE_W-1:0];
				REG_ACCEL_HIGH: accel_high_q <= pwdata[SAMPLE_W-1:0];
				REG_BRAKE_LOW:  brake_low_q  <= pwdata[SAMPLE_W-1:0];
				REG_BRAKE_HIGH: brake_high_q <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ACCEL_LOW:  prdata = 32'(accel_low_q);
			REG_ACCEL_HIGH: prdata = 32'(accel_high_q);
			REG_BRAKE_LOW:  prdata = 32'(brake_low_q);
			REG_BRAKE_HIGH: prdata = 32'(brake_high_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- input side ----------------
	// a new item enters once both lanes have handed their last result over
	assign s_axis_tready = st_accel.idle && st_brake.idle;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// entries below the fill count have been written since reset
	assign fill_next = (fill_q == FULL_FILL) ? fill_q : fill_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (in_accept) begin
			slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			fill_q <= fill_next;
		end
	end

	// ---------------- lanes ----------------
	assign ctl_accel.start    = in_accept;
	assign ctl_accel.ack      = merge;
	assign ctl_accel.supply   = s_axis_tdata[11:0];
	assign ctl_accel.pedal    = s_axis_tdata[23:12];
	assign ctl_accel.cal_low  = accel_low_q;
	assign ctl_accel.cal_high = accel_high_q;

	assign ctl_brake.start    = in_accept;
	assign ctl_brake.ack      = merge;
	assign ctl_brake.supply   = s_axis_tdata[11:0];
	assign ctl_brake.pedal    = s_axis_tdata[35:24];
	assign ctl_brake.cal_low  = brake_low_q;
	assign ctl_brake.cal_high = brake_high_q;

	rtmpf_lane #(
		.FILTER_DEPTH(FILTER_DEPTH)
	) u_lane_accel (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_accel),
		.slot   (slot_q),
		.fill   (fill_next),
		.st     (st_accel)
	);

	rtmpf_lane #(
		.FILTER_DEPTH(FILTER_DEPTH)
	) u_lane_brake (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_brake),
		.slot   (slot_q),
		.fill   (fill_next),
		.st     (st_brake)
	);

	// ---------------- merge and output register ----------------
	// wait until both lanes are done; load when the output register is free
	assign merge = st_accel.done && st_brake.done && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else if (merge) begin
			m_valid_q <= 1'b1;
			m_data_q  <= {st_brake.position, st_accel.position};
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

### hw/rtl/rtmpf_checker.sv
// port-level checks of the pedal filter top level, bound to it below
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rtmpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// a stalled result item holds
	`RTMPF_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

	// one item in work at a time: ready drops right after an accept
	`RTMPF_ASSERT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

	// a result never shows up in the cycle right after an accept
	`RTMPF_ASSERT(a_no_instant_result, clk, arst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))

	// positions stay within -32767..32767
	`RTMPF_ASSERT_NEVER(a_pos_range, clk, arst_n, m_axis_tvalid && (m_axis_tdata[15:0] == 16'h8000 || m_axis_tdata[31:16] == 16'h8000))

endmodule

bind ratiometric_trimmed_mean_pedal_filter_unit rtmpf_checker u_rtmpf_checker (.*);

`default_nettype wire
